[hdl/assert_macros.svh]
// Assertion macros used by the trace buffer back end (orc_back).
// Uses the clock i_clk and the active-low reset i_rst_n of the including module.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ORC_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

`define ORC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ORC_ASSERT_ALWAYS(lbl, expr, msg)

`define ORC_ASSERT_IMPLIES(lbl, ante, cons, msg)

`endif

`endif

[hdl/orc_pkg.sv]
// Shared types and constants of the overwriting ring trace buffer.
// Used by orc_front, orc_back and the top level; depends on nothing.
package orc_pkg;

    localparam int DEPTH       = 64;
    localparam int ENTRY_BITS  = 64;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int CAP_W       = 7;
    localparam int COUNT_W     = 32;

    // Command queue between front and back; depth must be a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_SNAP  = 2'd1;
    localparam logic [1:0] MODE_STATS = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_SNAP,
        OP_STATS,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] message;
    } t_in_item;

    typedef struct packed {
        logic                kind;
        logic                has_entry;
        logic [63:0]         entry_data;
        logic                last;
        logic [CAP_W-1:0]    fill_level;
        logic [COUNT_W-1:0]  total_count;
        logic [COUNT_W-1:0]  dropped_count;
    } t_out_item;

    typedef struct packed {
        t_op                   op;
        logic [ENTRY_BITS-1:0] msg;
    } t_cmd;

endpackage

[hdl/orc_front.sv]
// Front end of the trace buffer: accepts requests, decodes them into commands
// and holds them in a short queue for the back end. Depends on orc_pkg.
module orc_front import orc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_item,
    output logic     o_in_stall,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_pop
);

    t_cmd              r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;
    logic              full;
    logic              wr_en;
    t_cmd              dec_cmd;

    assign full       = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_in_stall = full;
    assign wr_en      = i_in_valid && !full;

    always_comb begin
        dec_cmd.msg = '0;
        unique case (i_in_item.mode)
            MODE_PUSH: begin
                dec_cmd.op  = OP_PUSH;
                dec_cmd.msg = i_in_item.message[ENTRY_BITS-1:0];
            end
            MODE_SNAP:  dec_cmd.op = OP_SNAP;
            MODE_STATS: dec_cmd.op = OP_STATS;
            MODE_CLEAR: dec_cmd.op = OP_CLEAR;
            default:    dec_cmd.op = OP_CLEAR;
        endcase
    end

    always_comb begin
        n_wr_ptr = wr_en ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_cmd_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (wr_en && !i_cmd_pop) begin
            n_count = r_count + 1'b1;
        end else if (!wr_en && i_cmd_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_queue[r_wr_ptr] <= dec_cmd;
        end
    end

    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rd_ptr];

endmodule

[hdl/orc_back.sv]
// Back end of the trace buffer: ring memory, head and fill tracking, counters,
// snapshot read pipeline and the output register. Depends on orc_pkg.
`include "assert_macros.svh"

module orc_back import orc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_cmd_pop,
    output logic             o_out_valid,
    output t_out_item        o_out_item,
    input  logic             i_out_stall
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SNAP = 1'b1;

    logic [ENTRY_BITS-1:0] r_mem [DEPTH];

    logic               r_state;
    logic [CNT_W-1:0]   r_cap;
    logic [PTR_W-1:0]   r_head;
    logic [CNT_W-1:0]   r_held;
    logic [COUNT_W-1:0] r_total;
    logic [COUNT_W-1:0] r_dropped;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_left;
    logic               r_rd_vld;
    logic               r_out_valid;

    logic               n_state;
    logic [CNT_W-1:0]   n_cap;
    logic [PTR_W-1:0]   n_head;
    logic [CNT_W-1:0]   n_held;
    logic [COUNT_W-1:0] n_total;
    logic [COUNT_W-1:0] n_dropped;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_left;
    logic               n_rd_vld;
    logic               n_out_valid;

    logic [ENTRY_BITS-1:0] r_rd_data;
    logic                  r_rd_last;
    t_out_item             r_out_item;

    logic       out_free;
    logic       pop;
    logic       do_push;
    logic       do_clear;
    logic       start_snap;
    logic       load_res;
    logic       rd_en;
    logic       move;
    t_out_item  res_item;
    t_out_item  snap_item;
    logic [CNT_W-1:0] cap_sat;

    // Advance a ring index, wrapping at the active capacity.
    function automatic logic [PTR_W-1:0] f_wrap_inc(input logic [PTR_W-1:0] ptr,
                                                    input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] nx;
        nx = CNT_W'(ptr) + CNT_W'(1);
        return (nx == cap) ? '0 : PTR_W'(nx);
    endfunction

    assign out_free = !r_out_valid || !i_out_stall;
    assign cap_sat  = (i_cfg_wdata > CAP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(i_cfg_wdata);

    // Command dispatch. Commands that produce a single result wait until the
    // snapshot read stage has drained so results leave in request order.
    always_comb begin
        pop        = 1'b0;
        do_push    = 1'b0;
        do_clear   = 1'b0;
        start_snap = 1'b0;
        load_res   = 1'b0;
        res_item   = '0;
        res_item.last = 1'b1;
        if (r_state == ST_IDLE && i_cmd_valid && !i_cfg_we) begin
            unique case (i_cmd.op)
                OP_PUSH: begin
                    pop     = 1'b1;
                    do_push = (r_cap != '0);
                end
                OP_CLEAR: begin
                    pop      = 1'b1;
                    do_clear = 1'b1;
                end
                OP_STATS: begin
                    if (!r_rd_vld && out_free) begin
                        pop      = 1'b1;
                        load_res = 1'b1;
                        res_item.kind          = 1'b1;
                        res_item.fill_level    = CAP_W'(r_held);
                        res_item.total_count   = r_total;
                        res_item.dropped_count = r_dropped;
                    end
                end
                OP_SNAP: begin
                    if (r_held == '0) begin
                        // Empty ring: a single marker result.
                        if (!r_rd_vld && out_free) begin
                            pop      = 1'b1;
                            load_res = 1'b1;
                        end
                    end else begin
                        pop        = 1'b1;
                        start_snap = 1'b1;
                    end
                end
                default: pop = 1'b0;
            endcase
        end
    end

    assign o_cmd_pop = pop;
    assign rd_en     = (r_state == ST_SNAP) && (!r_rd_vld || out_free);
    assign move      = r_rd_vld && out_free;

    always_comb begin
        snap_item            = '0;
        snap_item.has_entry  = 1'b1;
        snap_item.entry_data = 64'(r_rd_data);
        snap_item.last       = r_rd_last;
    end

    always_comb begin
        n_state     = r_state;
        n_cap       = r_cap;
        n_head      = r_head;
        n_held      = r_held;
        n_total     = r_total;
        n_dropped   = r_dropped;
        n_rd_ptr    = r_rd_ptr;
        n_left      = r_left;
        n_rd_vld    = rd_en ? 1'b1 : (move ? 1'b0 : r_rd_vld);
        n_out_valid = out_free ? (load_res || move) : r_out_valid;

        if (i_cfg_we) begin
            n_cap     = cap_sat;
            n_head    = '0;
            n_held    = '0;
            n_total   = '0;
            n_dropped = '0;
        end else if (do_clear) begin
            n_head    = '0;
            n_held    = '0;
            n_total   = '0;
            n_dropped = '0;
        end else if (do_push) begin
            n_head = f_wrap_inc(r_head, r_cap);
            if (r_held == r_cap) begin
                if (r_dropped != '1) begin
                    n_dropped = r_dropped + COUNT_W'(1);
                end
            end else begin
                n_held = r_held + CNT_W'(1);
            end
            if (r_total != '1) begin
                n_total = r_total + COUNT_W'(1);
            end
        end

        if (start_snap) begin
            // A full ring starts at the head, where the oldest entry sits.
            n_state  = ST_SNAP;
            n_rd_ptr = (r_held == r_cap) ? r_head : '0;
            n_left   = r_held;
        end else if (rd_en) begin
            n_rd_ptr = f_wrap_inc(r_rd_ptr, r_cap);
            n_left   = r_left - CNT_W'(1);
            if (r_left == CNT_W'(1)) begin
                n_state = ST_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap       <= CNT_W'(DEPTH);
            r_head      <= '0;
            r_held      <= '0;
            r_total     <= '0;
            r_dropped   <= '0;
            r_rd_ptr    <= '0;
            r_left      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cap       <= n_cap;
            r_head      <= n_head;
            r_held      <= n_held;
            r_total     <= n_total;
            r_dropped   <= n_dropped;
            r_rd_ptr    <= n_rd_ptr;
            r_left      <= n_left;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_head] <= i_cmd.msg;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_ptr];
            r_rd_last <= (r_left == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_item <= load_res ? res_item : snap_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    logic [CNT_W-1:0] head_ext;
    assign head_ext = CNT_W'(r_head);

    `ORC_ASSERT_ALWAYS(a_held_within_cap, r_held <= r_cap, "fill level exceeds capacity")
    `ORC_ASSERT_ALWAYS(a_head_within_cap, (r_cap == '0 && r_head == '0) || (head_ext < r_cap), "head pointer outside the active ring")
    `ORC_ASSERT_IMPLIES(a_snap_has_work, r_state == ST_SNAP, r_left != '0, "snapshot running with no entries left")
    `ORC_ASSERT_IMPLIES(a_stats_is_last, r_out_valid && r_out_item.kind, r_out_item.last && !r_out_item.has_entry, "stats report not a single last result")

endmodule

[hdl/overwrite_ring_trace_buffer.sv]
// Pushes are taken one per cycle while o_in_stall is low; a push or clear is applied when
// popped from the queue; a stats report or empty marker goes to the output register on its pop.
// A snapshot of N entries moves through the read stage one per cycle while the output is not
// stalled, limited by the memory's single read port; the back end pops nothing else meanwhile.
// Synchronous active-low reset empties the ring and queue, zeroes the counters and sets the
// capacity to the full depth; the entry memory itself is not cleared.
module overwrite_ring_trace_buffer import orc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    input  t_in_item         i_in_item,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output t_out_item        o_out_item,
    input  logic             i_out_stall
);

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    orc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    orc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule
